FILE: src/st_pkg.sv
// Shared types, character constants and character-class helpers for the source tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package st_pkg;

    // Default width of the position and length counters
    localparam int POS_WIDTH_DEF = 16;

    // Depth of the result queue
    localparam int RESQ_DEPTH = 4;

    // Token kinds as they appear on the output
    typedef enum logic [2:0] {
        KIND_EOF   = 3'd0,
        KIND_INT   = 3'd1,
        KIND_IDENT = 3'd2,
        KIND_STR   = 3'd3,
        KIND_OP    = 3'd4,
        KIND_ERR   = 3'd5
    } tok_kind_t;

    // Characters with a special role
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result token
    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  first_char;
        logic        unterminated;
        logic        last;
    } tok_t;

    // Up to two tokens produced by one input item, in output order
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } tok_push_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    // Space, TAB, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_quote(input logic [7:0] b);
        return b inside {CH_DQUOTE, CH_SQUOTE};
    endfunction

    // Operators that may take a trailing '='
    function automatic logic is_op_eq(input logic [7:0] b);
        return b inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
                         CH_BANG, CH_LT, CH_GT, CH_EQ};
    endfunction

    // Operators that may be doubled or take a trailing '='
    function automatic logic is_op_dbl(input logic [7:0] b);
        return b inside {CH_AMP, CH_PIPE};
    endfunction

    // One-byte punctuation
    function automatic logic is_op_single(input logic [7:0] b);
        return b inside {CH_LPAREN, CH_RPAREN, CH_SEMI, CH_COMMA, CH_COLON,
                         CH_LBRACE, CH_RBRACE};
    endfunction

endpackage

`default_nettype wire

FILE: src/st_scan.sv
// Scanner state and per-byte token decision for the source tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module st_scan #(
    parameter int POS_WIDTH = st_pkg::POS_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic             in_eos,
    input  wire logic [7:0]       in_byte,
    output st_pkg::tok_push_t     push
);
    import st_pkg::*;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_INT   = 7'b0000010,
        MODE_IDENT = 7'b0000100,
        MODE_STR   = 7'b0001000,
        MODE_OPEQ  = 7'b0010000,
        MODE_OPDBL = 7'b0100000,
        MODE_HALT  = 7'b1000000
    } mode_t;

    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0] POS_TWO = POS_WIDTH'(2);

    mode_t                mode_reg,   mode_next;
    logic [POS_WIDTH-1:0] pos_reg,    pos_next;
    logic [POS_WIDTH-1:0] start_reg,  start_next;
    logic [POS_WIDTH-1:0] length_reg, length_next;
    logic [7:0]           open_reg,   open_next;

    // Token starting at the current byte
    mode_t                beg_mode;
    logic                 beg_upd;
    logic [POS_WIDTH-1:0] beg_start;
    logic [POS_WIDTH-1:0] beg_len;
    logic                 beg_emit;
    tok_t                 beg_tok;

    // Closing token of the pending run, and the trailing token
    logic tok_a_v, tok_b_v;
    tok_t tok_a, tok_b;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] clamp16(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH+15:0] ext;
        ext = {16'b0, v};
        return (|ext[POS_WIDTH+15:16]) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic tok_t make_tok(input tok_kind_t k, input logic [POS_WIDTH-1:0] s,
                                      input logic [POS_WIDTH-1:0] l, input logic [7:0] f,
                                      input logic u);
        tok_t t;
        t.kind         = k;
        t.start        = clamp16(s);
        t.len          = clamp16(l);
        t.first_char   = f;
        t.unterminated = u;
        t.last         = 1'b0;
        return t;
    endfunction

    // Classify the incoming byte as the start of a new token
    always_comb begin
        beg_mode  = MODE_IDLE;
        beg_upd   = 1'b1;
        beg_start = pos_reg;
        beg_len   = POS_ONE;
        beg_emit  = 1'b0;
        beg_tok   = make_tok(KIND_OP, pos_reg, POS_ONE, in_byte, 1'b0);
        if (is_space(in_byte)) begin
            beg_upd = 1'b0;
        end else if (is_quote(in_byte)) begin
            beg_mode  = MODE_STR;
            beg_start = sat_inc(pos_reg);
            beg_len   = '0;
        end else if (is_digit(in_byte)) begin
            beg_mode = MODE_INT;
        end else if (is_alpha(in_byte)) begin
            beg_mode = MODE_IDENT;
        end else if (is_op_eq(in_byte)) begin
            beg_mode = MODE_OPEQ;
        end else if (is_op_dbl(in_byte)) begin
            beg_mode = MODE_OPDBL;
        end else if (is_op_single(in_byte)) begin
            beg_emit = 1'b1;
        end else begin
            beg_emit     = 1'b1;
            beg_tok.kind = KIND_ERR;
            beg_mode     = MODE_HALT;
        end
    end

    // Mode update and token emission for one item
    always_comb begin
        logic take_begin;
        take_begin  = 1'b0;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        length_next = length_reg;
        open_next   = open_reg;
        tok_a_v     = 1'b0;
        tok_b_v     = 1'b0;
        tok_a       = make_tok(KIND_OP, start_reg, POS_ONE, open_reg, 1'b0);
        tok_b       = make_tok(KIND_EOF, pos_reg, '0, 8'h00, 1'b0);

        if (mode_reg == MODE_HALT) begin
            // halted: nothing until reset
        end else if (in_eos) begin
            // flush the pending token, then eof, then back to reset state
            tok_b_v = 1'b1;
            case (mode_reg)
                MODE_INT: begin
                    tok_a_v = 1'b1;
                    tok_a   = make_tok(KIND_INT, start_reg, length_reg, open_reg, 1'b0);
                end
                MODE_IDENT: begin
                    tok_a_v = 1'b1;
                    tok_a   = make_tok(KIND_IDENT, start_reg, length_reg, open_reg, 1'b0);
                end
                MODE_STR: begin
                    tok_a_v = 1'b1;
                    tok_a   = make_tok(KIND_STR, start_reg, length_reg, open_reg, 1'b1);
                end
                MODE_OPEQ, MODE_OPDBL: begin
                    tok_a_v = 1'b1;
                end
                default: begin
                end
            endcase
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            start_next  = '0;
            length_next = '0;
            open_next   = 8'h00;
        end else begin
            case (mode_reg)
                MODE_INT: begin
                    if (is_digit(in_byte)) begin
                        length_next = sat_inc(length_reg);
                    end else begin
                        tok_a_v    = 1'b1;
                        tok_a      = make_tok(KIND_INT, start_reg, length_reg, open_reg, 1'b0);
                        take_begin = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_digit(in_byte) || is_alpha(in_byte)) begin
                        length_next = sat_inc(length_reg);
                    end else begin
                        tok_a_v    = 1'b1;
                        tok_a      = make_tok(KIND_IDENT, start_reg, length_reg, open_reg,
                                              1'b0);
                        take_begin = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (in_byte == open_reg) begin
                        tok_a_v   = 1'b1;
                        tok_a     = make_tok(KIND_STR, start_reg, length_reg, open_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        length_next = sat_inc(length_reg);
                    end
                end
                MODE_OPEQ, MODE_OPDBL: begin
                    tok_a_v = 1'b1;
                    if (in_byte == CH_EQ ||
                        (mode_reg == MODE_OPDBL && in_byte == open_reg)) begin
                        tok_a     = make_tok(KIND_OP, start_reg, POS_TWO, open_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        take_begin = 1'b1;
                    end
                end
                default: begin
                    take_begin = 1'b1;
                end
            endcase

            if (take_begin) begin
                mode_next = beg_mode;
                tok_b_v   = beg_emit;
                tok_b     = beg_tok;
                if (beg_upd) begin
                    start_next  = beg_start;
                    length_next = beg_len;
                    open_next   = in_byte;
                end
            end
            pos_next = sat_inc(pos_reg);
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb begin
        push       = '0;
        push.tok0  = tok_a_v ? tok_a : tok_b;
        push.tok1  = tok_b;
        if (in_fire) begin
            push.count = {1'b0, tok_a_v} + {1'b0, tok_b_v};
        end
        if (tok_a_v && tok_b_v) begin
            push.tok1.last = 1'b1;
        end else begin
            push.tok0.last = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            open_reg   <= 8'h00;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            open_reg   <= open_next;
        end
    end

`ifndef ASSERT_OFF
    // once halted, only reset leaves the halt mode
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("scanner left halt mode without reset");

    // a halted scanner produces no tokens
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |-> push.count == 2'd0)
        else $error("token produced while halted");

    // the end marker always yields an eof token last
    a_eos_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_eos && mode_reg != MODE_HALT) |->
        (push.count != 2'd0 && push.tok1.kind == KIND_EOF) ##1 pos_reg == '0)
        else $error("end of source without eof token");
`endif

endmodule

`default_nettype wire

FILE: src/st_resq.sv
// Small result queue: takes up to two tokens per cycle, delivers one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module st_resq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  st_pkg::tok_push_t      push,
    output logic                   space_ok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output st_pkg::tok_t           out_tok
);
    import st_pkg::*;

    localparam int PTR_W = $clog2(RESQ_DEPTH);
    localparam int CNT_W = $clog2(RESQ_DEPTH + 1);
    localparam logic [CNT_W-1:0] SPACE_LIMIT = CNT_W'(RESQ_DEPTH - 2);
    localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(RESQ_DEPTH);

    tok_t             entry_reg [RESQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign space_ok     = (count_reg <= SPACE_LIMIT);
    assign out_valid    = (count_reg != '0);
    assign out_tok      = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

`ifndef ASSERT_OFF
    // fill count never exceeds the depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("result queue overflow");

    // tokens arrive only when two entries are free
    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> space_ok)
        else $error("push into full result queue");

    // a pair of tokens carries the run end on the second only
    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (push.tok1.last && !push.tok0.last))
        else $error("wrong run end marking on token pair");
`endif

endmodule

`default_nettype wire

FILE: src/source_tokenizer.sv
// Top level of the streaming source tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// Source text enters one byte per item (s_tuser[0] = 0) and an item with
// s_tuser[0] = 1 ends the source; each item gives zero, one or two tokens
// on the master side, the last of them flagged by m_tlast. An item is
// decoded in the cycle it is accepted and its tokens land in a four-entry
// result queue, so one item can be accepted every cycle; s_tready drops
// while fewer than two queue entries are free. The master side delivers one
// token per cycle while m_tready is up, so an item that closes one token and
// emits another (or the end marker after a pending token) yields two tokens,
// and the sustained rate is one item per cycle as long as items average at
// most one token. An unknown byte gives an error token and the tokenizer
// then swallows every item until reset. Offsets and lengths count in
// POS_WIDTH bits, saturate there and are clamped to 16 bits on the output.
module source_tokenizer #(
    parameter int POS_WIDTH = st_pkg::POS_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] src_byte
    input  wire logic        s_tuser,  // [0] func (1 = end of source)
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // [15:0] tok_start, [31:16] tok_len,
                                       // [39:32] tok_first_char
    output logic [7:0]       m_tuser,  // [2:0] tok_kind, [3] unterminated, [7:4] zero
    output logic             m_tlast   // last_of_run
);
    import st_pkg::*;

    logic      in_fire;
    tok_push_t push;
    tok_t      out_tok;

    assign in_fire = s_tvalid && s_tready;

    st_scan #(
        .POS_WIDTH(POS_WIDTH)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_eos  (s_tuser),
        .in_byte (s_tdata),
        .push    (push)
    );

    st_resq u_resq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // Output packing
    assign m_tdata = {out_tok.first_char, out_tok.len, out_tok.start};
    assign m_tuser = {4'b0000, out_tok.unterminated, out_tok.kind};
    assign m_tlast = out_tok.last;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the streaming source tokenizer: token predictor and scoreboard.
`timescale 1ns / 1ps

module tb;
    import st_pkg::*;

    localparam int          STALL_LIMIT  = 4000;   // cycles with no item moving
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_PRINTS   = 40;
    localparam logic [15:0] POS_SAT      = 16'hFFFF;
    localparam logic        FUNC_BYTE    = 1'b0;
    localparam logic        FUNC_END     = 1'b1;

    // Scanner states of the token predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_IDENT,
        SCAN_STR,
        SCAN_OP_EQ,
        SCAN_OP_DBL,
        SCAN_HALT
    } scan_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    // Flow-control mix of the current phase, in percent
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int items_sent     = 0;
    int tokens_checked = 0;
    int mismatch_count = 0;

    // Token predictor state
    scan_mode_t  lex_mode      = SCAN_IDLE;
    logic [15:0] lex_pos       = 16'd0;
    logic [15:0] lex_tok_start = 16'd0;
    logic [15:0] lex_tok_len   = 16'd0;
    logic [7:0]  lex_open      = 8'h00;

    tok_t item_toks[$];       // tokens caused by the item being predicted
    tok_t pending_tokens[$];  // tokens still owed by the block, oldest first

    source_tokenizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Character classes (plain ASCII)
    // ---------------------------------------------------------------
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == POS_SAT) ? v : v + 16'd1;
    endfunction

    function automatic bit digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit alpha_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit space_byte(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit quote_byte(input logic [7:0] b);
        return b == CH_DQUOTE || b == CH_SQUOTE;
    endfunction

    function automatic bit op_eq_byte(input logic [7:0] b);
        case (b)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
            CH_BANG, CH_LT, CH_GT, CH_EQ: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit op_dbl_byte(input logic [7:0] b);
        return b == CH_AMP || b == CH_PIPE;
    endfunction

    function automatic bit op_single_byte(input logic [7:0] b);
        case (b)
            CH_LPAREN, CH_RPAREN, CH_SEMI, CH_COMMA,
            CH_COLON, CH_LBRACE, CH_RBRACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Any byte that does not stop the block with an error token
    function automatic bit known_byte(input logic [7:0] b);
        return space_byte(b) || digit_byte(b) || alpha_byte(b) || quote_byte(b) ||
               op_eq_byte(b) || op_dbl_byte(b) || op_single_byte(b);
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    task automatic emit_tok(input tok_kind_t kind, input logic [15:0] start,
                            input logic [15:0] len, input logic [7:0] first_byte,
                            input logic unterm);
        tok_t t;
        t.kind         = kind;
        t.start        = start;
        t.len          = len;
        t.first_char   = first_byte;
        t.unterminated = unterm;
        t.last         = 1'b0;
        item_toks.push_back(t);
    endtask

    // A byte that starts a new token (or is skipped as whitespace)
    task automatic open_token(input logic [7:0] b, input logic [15:0] p);
        lex_mode = SCAN_IDLE;
        if (!space_byte(b)) begin
            lex_open      = b;
            lex_tok_start = p;
            lex_tok_len   = 16'd1;
            if (quote_byte(b)) begin
                // string text starts after the quote
                lex_mode      = SCAN_STR;
                lex_tok_start = sat_inc(p);
                lex_tok_len   = 16'd0;
            end else if (digit_byte(b)) begin
                lex_mode = SCAN_INT;
            end else if (alpha_byte(b)) begin
                lex_mode = SCAN_IDENT;
            end else if (op_eq_byte(b)) begin
                lex_mode = SCAN_OP_EQ;
            end else if (op_dbl_byte(b)) begin
                lex_mode = SCAN_OP_DBL;
            end else if (op_single_byte(b)) begin
                emit_tok(KIND_OP, p, 16'd1, b, 1'b0);
            end else begin
                emit_tok(KIND_ERR, p, 16'd1, b, 1'b0);
                lex_mode = SCAN_HALT;
            end
        end
    endtask

    // Work out the tokens one accepted item causes and queue them
    task automatic predict_item(input logic func, input logic [7:0] b);
        logic [15:0] p;
        tok_t        t;
        p = lex_pos;
        item_toks.delete();
        if (lex_mode != SCAN_HALT) begin
            if (func) begin
                // end of source: flush the pending token, then eof
                case (lex_mode)
                    SCAN_INT:   emit_tok(KIND_INT, lex_tok_start, lex_tok_len, lex_open, 1'b0);
                    SCAN_IDENT: emit_tok(KIND_IDENT, lex_tok_start, lex_tok_len, lex_open, 1'b0);
                    SCAN_STR:   emit_tok(KIND_STR, lex_tok_start, lex_tok_len, lex_open, 1'b1);
                    SCAN_OP_EQ, SCAN_OP_DBL: begin
                        emit_tok(KIND_OP, lex_tok_start, 16'd1, lex_open, 1'b0);
                    end
                    default: ;
                endcase
                emit_tok(KIND_EOF, p, 16'd0, 8'h00, 1'b0);
                lex_mode      = SCAN_IDLE;
                lex_pos       = 16'd0;
                lex_tok_start = 16'd0;
                lex_tok_len   = 16'd0;
                lex_open      = 8'h00;
            end else begin
                case (lex_mode)
                    SCAN_INT: begin
                        if (digit_byte(b)) begin
                            lex_tok_len = sat_inc(lex_tok_len);
                        end else begin
                            emit_tok(KIND_INT, lex_tok_start, lex_tok_len, lex_open, 1'b0);
                            open_token(b, p);
                        end
                    end
                    SCAN_IDENT: begin
                        if (digit_byte(b) || alpha_byte(b)) begin
                            lex_tok_len = sat_inc(lex_tok_len);
                        end else begin
                            emit_tok(KIND_IDENT, lex_tok_start, lex_tok_len, lex_open, 1'b0);
                            open_token(b, p);
                        end
                    end
                    SCAN_STR: begin
                        if (b == lex_open) begin
                            emit_tok(KIND_STR, lex_tok_start, lex_tok_len, lex_open, 1'b0);
                            lex_mode = SCAN_IDLE;
                        end else begin
                            lex_tok_len = sat_inc(lex_tok_len);
                        end
                    end
                    SCAN_OP_EQ, SCAN_OP_DBL: begin
                        if (b == CH_EQ || (lex_mode == SCAN_OP_DBL && b == lex_open)) begin
                            emit_tok(KIND_OP, lex_tok_start, 16'd2, lex_open, 1'b0);
                            lex_mode = SCAN_IDLE;
                        end else begin
                            emit_tok(KIND_OP, lex_tok_start, 16'd1, lex_open, 1'b0);
                            open_token(b, p);
                        end
                    end
                    default: open_token(b, p);
                endcase
                lex_pos = sat_inc(p);
            end
        end
        // flag the final token of this item
        if (item_toks.size() > 0) begin
            t      = item_toks.pop_back();
            t.last = 1'b1;
            item_toks.push_back(t);
        end
        foreach (item_toks[i]) pending_tokens.push_back(item_toks[i]);
    endtask

    // ---------------------------------------------------------------
    // Scoreboard
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] token %0d, %s: expected 0x%0h, got 0x%0h",
                     $time, tokens_checked, what, want, got);
    endtask

    task automatic check_token();
        tok_t want;
        if (pending_tokens.size() == 0) begin
            report_mismatch("token with none outstanding, kind", 0, 32'(m_tuser[2:0]));
        end else begin
            want = pending_tokens.pop_front();
            if (m_tuser[2:0] != want.kind)
                report_mismatch("tok_kind", 32'(want.kind), 32'(m_tuser[2:0]));
            if (m_tdata[15:0] != want.start)
                report_mismatch("tok_start", 32'(want.start), 32'(m_tdata[15:0]));
            if (m_tdata[31:16] != want.len)
                report_mismatch("tok_len", 32'(want.len), 32'(m_tdata[31:16]));
            if (m_tdata[39:32] != want.first_char)
                report_mismatch("tok_first_char", 32'(want.first_char),
                                32'(m_tdata[39:32]));
            if (m_tuser[3] != want.unterminated)
                report_mismatch("unterminated", 32'(want.unterminated), 32'(m_tuser[3]));
            if (m_tlast != want.last)
                report_mismatch("last_of_run", 32'(want.last), 32'(m_tlast));
        end
        tokens_checked++;
    endtask

    // Predict before checking so ordering within the edge is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_token();
        end
    end

    // Result-side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: ends the run when no item moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Send one item; tvalid stays up if the next call sends at once
    task automatic send_item(input logic func, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
    endtask

    // Hold off the sender until every outstanding token has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_tokens.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 61) < 10) ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] rand_op_eq();
        case ($urandom_range(0, 8))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            3: return CH_SLASH;
            4: return CH_PCT;
            5: return CH_BANG;
            6: return CH_LT;
            7: return CH_GT;
            default: return CH_EQ;
        endcase
    endfunction

    function automatic logic [7:0] rand_op_single();
        case ($urandom_range(0, 6))
            0: return CH_LPAREN;
            1: return CH_RPAREN;
            2: return CH_SEMI;
            3: return CH_COMMA;
            4: return CH_COLON;
            5: return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // One well-formed token with random content, now and then broken or noise
    task automatic send_random_token();
        int          pick;
        int          n;
        logic [7:0]  q;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(FUNC_BYTE, rand_digit());
        end else if (pick < 30) begin
            n = $urandom_range(0, 6);
            send_item(FUNC_BYTE, rand_letter());
            repeat (n) send_item(FUNC_BYTE, rand_alnum());
        end else if (pick < 45) begin
            // string: any content byte except its own quote; some left open
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            send_item(FUNC_BYTE, q);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255)); while (b == q);
                send_item(FUNC_BYTE, b);
            end
            if ($urandom_range(0, 7) != 0) send_item(FUNC_BYTE, q);
        end else if (pick < 60) begin
            send_item(FUNC_BYTE, rand_op_eq());
            if ($urandom_range(0, 1)) send_item(FUNC_BYTE, CH_EQ);
        end else if (pick < 72) begin
            q = $urandom_range(0, 1) ? CH_AMP : CH_PIPE;
            send_item(FUNC_BYTE, q);
            case ($urandom_range(0, 2))
                0: send_item(FUNC_BYTE, q);
                1: send_item(FUNC_BYTE, CH_EQ);
                default: ;
            endcase
        end else if (pick < 80) begin
            send_item(FUNC_BYTE, rand_op_single());
        end else if (pick < 92) begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(FUNC_BYTE, rand_space());
        end else begin
            do b = 8'($urandom_range(0, 127)); while (!known_byte(b));
            send_item(FUNC_BYTE, b);
        end
    endtask

    task automatic send_random_source();
        int ntok;
        ntok = $urandom_range(1, 12);
        repeat (ntok) begin
            send_random_token();
            if ($urandom_range(0, 3) == 0) send_item(FUNC_BYTE, rand_space());
        end
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Empty source, each token kind but the error token, whitespace, byte extremes in strings,
    // pending operator and open string flushed by the end marker
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(FUNC_END, 8'hFF);
        send_item(FUNC_BYTE, 8'h20);
        send_text("Zz9>=0|");
        send_item(FUNC_END, 8'h00);
        send_item(FUNC_BYTE, 8'h09);
        send_item(FUNC_BYTE, CH_SQUOTE);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, CH_DQUOTE);
        send_item(FUNC_BYTE, 8'hFF);
        send_item(FUNC_BYTE, CH_SQUOTE);
        send_item(FUNC_BYTE, 8'h0D);
        send_text("&&)\"q");
        send_item(FUNC_END, 8'hA5);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        int stop_at;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = items_sent + n_items;
        // first source runs alone, with the sender held until it drains
        send_random_source();
        wait_for_results();
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) wait_for_results();
            send_random_source();
        end
        wait_for_results();
    endtask

    // Unknown byte after a pending identifier; everything after it is dropped
    task automatic test_halt_after_error();
        logic [7:0] bad;
        src_idle_pct   = 11;
        sink_stall_pct = 11;
        send_text("ab");
        do bad = 8'($urandom_range(0, 255)); while (known_byte(bad));
        send_item(FUNC_BYTE, bad);
        repeat (40) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_item(FUNC_END, 8'h00);
        wait_for_results();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(0, 0, 385);
        test_random_traffic(78, 0, 385);
        test_random_traffic(0, 78, 385);
        test_random_traffic(11, 11, 385);
        test_halt_after_error();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Summary: %0d items sent, %0d tokens checked, %0d mismatches",
                 items_sent, tokens_checked, mismatch_count);
        $display("Covered all token kinds and operators, "
                 , "open strings at end, halt on bad byte, four flow-control mixes");
        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
